// ===== rtl/core/ale_pkg.sv =====
// ============================================================================
// ale_pkg
// Shared types and codes for the array list engine.
// ============================================================================
package ale_pkg;

    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [3:0] OP_INSERT     = 4'd2;
    localparam logic [3:0] OP_POP_BACK   = 4'd3;
    localparam logic [3:0] OP_POP_FRONT  = 4'd4;
    localparam logic [3:0] OP_ERASE      = 4'd5;
    localparam logic [3:0] OP_FIND       = 4'd6;
    localparam logic [3:0] OP_REMOVE_ONE = 4'd7;
    localparam logic [3:0] OP_REMOVE_ALL = 4'd8;
    localparam logic [3:0] OP_CLEAR      = 4'd9;
    localparam logic [3:0] OP_SORT       = 4'd10;
    localparam logic [3:0] OP_BSEARCH    = 4'd11;
    localparam logic [3:0] OP_DUMP       = 4'd12;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] value;
        logic [6:0]         position;
    } ale_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               found;
        logic [5:0]         index;
        logic [6:0]         count;
        logic signed [31:0] element;
        logic               last;
    } ale_out_t;

    // memory port request from the sequencer
    typedef struct packed {
        logic               rd_en;
        logic [AW-1:0]      rd_addr;
        logic               wr_en;
        logic [AW-1:0]      wr_addr;
        logic signed [31:0] wr_data;
    } ale_mem_req_t;

endpackage

// ===== rtl/core/ale_ram.sv =====
// ============================================================================
// ale_ram
// List storage: one write port, one read port, registered read data.
// ============================================================================
module ale_ram
    import ale_pkg::*;
(
    input  logic               aclk,
    input  ale_mem_req_t       req,
    output logic signed [31:0] rd_data
);

    logic signed [31:0] mem [CAPACITY];

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, read data registered
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== rtl/core/ale_seq.sv =====
// ============================================================================
// ale_seq
// Operation sequencer: walks the list through the memory port, one read and
// at most one write per step, and builds the result words.
// ============================================================================
module ale_seq
    import ale_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ale_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ale_out_t           m_data,
    output ale_mem_req_t       mreq,
    input  logic signed [31:0] rd_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;  // issue read (ptr, ptr-1 for insert, mid for bsearch)
    localparam logic [3:0] S_USE   = 4'd2;  // read data valid
    localparam logic [3:0] S_EMIT  = 4'd3;  // hand result to output register
    localparam logic [3:0] S_SORT1 = 4'd4;  // insertion sort: read key
    localparam logic [3:0] S_SORT2 = 4'd5;  // key back, read j-1
    localparam logic [3:0] S_SORT3 = 4'd6;  // compare and shift
    localparam logic [3:0] S_DUMP  = 4'd7;  // dump element data back
    localparam logic [3:0] S_INS   = 4'd8;  // insert shift data back

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [3:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      ptr_reg, ptr_next;   // read pointer
    logic [CW-1:0]      wp_reg, wp_next;     // write pointer / sort j
    logic [CW-1:0]      lo_reg, lo_next;     // bsearch left / sort i
    logic [CW-1:0]      hi_reg, hi_next;     // bsearch right + 1
    logic               hit_reg, hit_next;
    logic signed [31:0] key_reg, key_next;
    logic [2:0]         st_reg, st_next;
    logic [5:0]         idx_reg, idx_next;

    logic               ov_reg, ov_next;
    ale_out_t           od_reg, od_next;

    logic               cap_load;
    ale_out_t           cap_word;
    logic               out_free;
    logic [CW-1:0]      mid;

    assign out_free = !ov_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = ov_reg;
    assign m_data   = od_reg;
    assign mid      = lo_reg + ((hi_reg - lo_reg - 1'b1) >> 1);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_data.operation;
            val_reg <= s_data.value;
        end
        ptr_reg <= ptr_next;
        wp_reg  <= wp_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        hit_reg <= hit_next;
        key_reg <= key_next;
        st_reg  <= st_next;
        idx_reg <= idx_next;
        od_reg  <= od_next;
    end

    // output register
    always_comb begin
        ov_next = ov_reg;
        od_next = od_reg;
        if (m_ready) begin
            ov_next = 1'b0;
        end
        if (cap_load) begin
            ov_next = 1'b1;
            od_next = cap_word;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        wp_next    = wp_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        hit_next   = hit_reg;
        key_next   = key_reg;
        st_next    = st_reg;
        idx_next   = idx_reg;
        cap_load   = 1'b0;
        cap_word   = '0;
        mreq       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    st_next    = ST_OK;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    key_next   = s_data.value;
                    ptr_next   = '0;
                    wp_next    = '0;
                    state_next = S_EMIT;
                    case (s_data.operation)
                        OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                            if (cnt_reg >= CW'(CAPACITY)) begin
                                st_next = ST_FULL;
                            end else if (s_data.operation == OP_INSERT
                                         && s_data.position > 7'(cnt_reg)) begin
                                st_next = ST_BADPOS;
                            end else begin
                                // shift up from the end down to the slot
                                wp_next = (s_data.operation == OP_PUSH_BACK) ? cnt_reg
                                        : (s_data.operation == OP_PUSH_FRONT) ? '0
                                        : CW'(s_data.position);
                                ptr_next   = cnt_reg;
                                state_next = S_READ;
                            end
                        end
                        OP_POP_BACK: begin
                            if (cnt_reg == '0) st_next = ST_EMPTY;
                            else cnt_next = cnt_reg - 1'b1;
                        end
                        OP_POP_FRONT, OP_ERASE: begin
                            if (cnt_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else if (s_data.operation == OP_ERASE
                                         && s_data.position >= 7'(cnt_reg)) begin
                                st_next = ST_BADPOS;
                            end else begin
                                // compaction skipping the erased slot
                                lo_next    = (s_data.operation == OP_ERASE)
                                           ? CW'(s_data.position) : '0;
                                state_next = S_READ;
                            end
                        end
                        OP_FIND, OP_REMOVE_ONE, OP_REMOVE_ALL: begin
                            state_next = S_READ;
                        end
                        OP_CLEAR: cnt_next = '0;
                        OP_SORT: begin
                            lo_next    = CW'(1);
                            state_next = S_SORT1;
                        end
                        OP_BSEARCH: begin
                            lo_next    = '0;
                            hi_next    = cnt_reg;
                            state_next = S_READ;
                        end
                        OP_DUMP: begin
                            state_next = S_READ;
                        end
                        default: ;
                    endcase
                end
            end

            S_READ: begin
                unique case (op_reg)
                    OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                        if (ptr_reg == wp_reg) begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = AW'(wp_reg);
                            mreq.wr_data = val_reg;
                            cnt_next     = cnt_reg + 1'b1;
                            state_next   = S_EMIT;
                        end else begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = AW'(ptr_reg - 1'b1);
                            state_next   = S_INS;
                        end
                    end
                    OP_BSEARCH: begin
                        if (lo_reg >= hi_reg) begin
                            st_next    = ST_NOTFOUND;
                            state_next = S_EMIT;
                        end else begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = AW'(mid);
                            state_next   = S_USE;
                        end
                    end
                    OP_DUMP: begin
                        if (cnt_reg == '0) begin
                            state_next = S_EMIT;
                        end else if (out_free) begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = AW'(ptr_reg);
                            state_next   = S_DUMP;
                        end
                    end
                    default: begin
                        // linear walks: find, remove, erase, pop front
                        if (ptr_reg >= cnt_reg) begin
                            if (op_reg == OP_REMOVE_ALL) begin
                                cnt_next = wp_reg;
                            end else if (op_reg == OP_POP_FRONT
                                         || op_reg == OP_ERASE
                                         || (op_reg == OP_REMOVE_ONE && hit_reg)) begin
                                cnt_next = cnt_reg - 1'b1;
                            end else if (!hit_reg) begin
                                st_next = ST_NOTFOUND;
                            end
                            state_next = S_EMIT;
                        end else begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = AW'(ptr_reg);
                            state_next   = S_USE;
                        end
                    end
                endcase
            end

            S_INS: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = AW'(ptr_reg);
                mreq.wr_data = rd_data;
                ptr_next     = ptr_reg - 1'b1;
                state_next   = S_READ;
            end

            S_USE: begin
                state_next = S_READ;
                ptr_next   = ptr_reg + 1'b1;
                unique case (op_reg)
                    OP_BSEARCH: begin
                        if (val_reg < rd_data) begin
                            hi_next = mid;
                        end else if (val_reg > rd_data) begin
                            lo_next = mid + 1'b1;
                        end else begin
                            hit_next   = 1'b1;
                            idx_next   = 6'(mid);
                            state_next = S_EMIT;
                        end
                    end
                    OP_FIND: begin
                        if (rd_data == val_reg) begin
                            hit_next   = 1'b1;
                            idx_next   = 6'(ptr_reg);
                            state_next = S_EMIT;
                        end
                    end
                    OP_REMOVE_ALL: begin
                        if (rd_data != val_reg) begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = AW'(wp_reg);
                            mreq.wr_data = rd_data;
                            wp_next      = wp_reg + 1'b1;
                        end
                    end
                    OP_REMOVE_ONE: begin
                        // drop the first match, shift the rest down
                        if (!hit_reg && rd_data == val_reg) begin
                            hit_next = 1'b1;
                        end else begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = AW'(wp_reg);
                            mreq.wr_data = rd_data;
                            wp_next      = wp_reg + 1'b1;
                        end
                    end
                    default: begin
                        // pop front / erase: skip slot lo
                        if (ptr_reg != lo_reg) begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = AW'(wp_reg);
                            mreq.wr_data = rd_data;
                            wp_next      = wp_reg + 1'b1;
                        end
                    end
                endcase
            end

            S_DUMP: begin
                cap_load         = 1'b1;
                cap_word.status  = ST_OK;
                cap_word.count   = 7'(cnt_reg);
                cap_word.element = rd_data;
                cap_word.last    = (ptr_reg + 1'b1 == cnt_reg);
                ptr_next         = ptr_reg + 1'b1;
                state_next       = (ptr_reg + 1'b1 == cnt_reg) ? S_IDLE : S_READ;
            end

            S_SORT1: begin
                if (lo_reg >= cnt_reg) begin
                    state_next = S_EMIT;
                end else begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = AW'(lo_reg);
                    wp_next      = lo_reg;
                    state_next   = S_SORT2;
                end
            end

            S_SORT2: begin
                key_next     = rd_data;
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = AW'(wp_reg - 1'b1);
                state_next   = S_SORT3;
            end

            S_SORT3: begin
                if (rd_data > key_reg) begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = AW'(wp_reg);
                    mreq.wr_data = rd_data;
                    wp_next      = wp_reg - 1'b1;
                    if (wp_reg == CW'(1)) begin
                        // key lands at the front on the next pass
                        state_next = S_SORT3;
                    end else begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = AW'(wp_reg - 2'd2);
                    end
                end else begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = AW'(wp_reg);
                    mreq.wr_data = key_reg;
                    lo_next      = lo_reg + 1'b1;
                    state_next   = S_SORT1;
                end
                if (wp_reg == '0) begin
                    mreq         = '0;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = '0;
                    mreq.wr_data = key_reg;
                    wp_next      = wp_reg;
                    lo_next      = lo_reg + 1'b1;
                    state_next   = S_SORT1;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    cap_load        = 1'b1;
                    cap_word.status = st_reg;
                    cap_word.found  = hit_reg && (op_reg == OP_FIND
                                                  || op_reg == OP_BSEARCH);
                    cap_word.index  = (op_reg == OP_FIND || op_reg == OP_BSEARCH)
                                    ? idx_reg : '0;
                    cap_word.count  = 7'(cnt_reg);
                    cap_word.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/array_list_engine_top.sv =====
// ============================================================================
// array_list_engine_top
// Fixed-capacity ordered list of signed words with a request/result stream.
// ============================================================================
// Usage: one request word on s_ (operation, value, position) per operation.
// Each request gives one result word on m_, except dump, which gives one
// word per held element (one word when empty), the final one with last set.
// A new request is taken only once the previous one has finished its walk.
// Push, insert, erase, find and removes walk the list one memory read and
// write step at a time; pop back, clear and errors need no memory access;
// bsearch halves the range per read; dump reads one element per word; sort
// is an insertion sort, bounded by the single memory read port. The result
// sits in an output register, so a stalled receiver only holds the sequencer
// at the step that emits the next word.
// Reset (aresetn low, synchronous) empties the list; memory contents are
// not cleared and never read before being written.
module array_list_engine_top
    import ale_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ale_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ale_out_t m_data
);

    ale_mem_req_t       mreq;
    logic signed [31:0] rd_data;

    // sequencer
    ale_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    // list storage
    ale_ram u_ram (
        .aclk    (aclk),
        .req     (mreq),
        .rd_data (rd_data)
    );

endmodule
